// ===== hw/rtl/mte_pkg.sv =====
// Shared types, codes and the microcode program of the MIDI track event encoder.
`default_nettype none

package mte_pkg;

  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] upc_t;

  // Event codes on the action field
  localparam logic [2:0] ACT_NOTE_OFF  = 3'd0;
  localparam logic [2:0] ACT_NOTE_ON   = 3'd1;
  localparam logic [2:0] ACT_POLY_AT   = 3'd2;
  localparam logic [2:0] ACT_PROGRAM   = 3'd3;
  localparam logic [2:0] ACT_TEMPO     = 3'd4;
  localparam logic [2:0] ACT_TIME_SIG  = 3'd5;
  localparam logic [2:0] ACT_END_TRACK = 3'd6;
  localparam logic [2:0] ACT_NONE      = 3'd7;

  // Program entry points and the final step
  localparam upc_t UA_NOTE  = 5'd0;
  localparam upc_t UA_PROG  = 5'd4;
  localparam upc_t UA_TEMPO = 5'd7;
  localparam upc_t UA_TSIG  = 5'd14;
  localparam upc_t UA_EOT   = 5'd22;
  localparam upc_t UA_LAST  = 5'd25;

  typedef enum logic [2:0] {
    SRC_CONST  = 3'd0,  // literal byte
    SRC_VLQ    = 3'd1,  // current delta group with continuation bit
    SRC_STATUS = 3'd2,  // literal | action[1:0] << 4 | channel
    SRC_CHAN   = 3'd3,  // literal | channel
    SRC_P1     = 3'd4,
    SRC_P2     = 3'd5,
    SRC_PAY    = 3'd6   // payload byte selected by literal[1:0]
  } byte_src_t;

  typedef struct packed {
    byte_src_t   src;
    logic [7:0]  lit;
    logic        loop;  // repeat this step until the delta group index reaches zero
    logic        last;  // final byte of the event
  } ucode_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [27:0] delta;
    logic [3:0]  channel;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [31:0] payload;
  } event_t;

  function automatic ucode_t uc(input byte_src_t src, input logic [7:0] lit,
                                input logic loop, input logic last);
    ucode_t w;
    w.src  = src;
    w.lit  = lit;
    w.loop = loop;
    w.last = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    case (addr)
      // note off / note on / poly aftertouch
      5'd0:    w = uc(SRC_VLQ,    8'h00, 1'b1, 1'b0);
      5'd1:    w = uc(SRC_STATUS, 8'h80, 1'b0, 1'b0);
      5'd2:    w = uc(SRC_P1,     8'h00, 1'b0, 1'b0);
      5'd3:    w = uc(SRC_P2,     8'h00, 1'b0, 1'b1);
      // program change
      5'd4:    w = uc(SRC_CONST,  8'h00, 1'b0, 1'b0);
      5'd5:    w = uc(SRC_CHAN,   8'hC0, 1'b0, 1'b0);
      5'd6:    w = uc(SRC_P1,     8'h00, 1'b0, 1'b1);
      // tempo
      5'd7:    w = uc(SRC_VLQ,    8'h00, 1'b1, 1'b0);
      5'd8:    w = uc(SRC_CONST,  8'hFF, 1'b0, 1'b0);
      5'd9:    w = uc(SRC_CONST,  8'h51, 1'b0, 1'b0);
      5'd10:   w = uc(SRC_CONST,  8'h03, 1'b0, 1'b0);
      5'd11:   w = uc(SRC_PAY,    8'h02, 1'b0, 1'b0);
      5'd12:   w = uc(SRC_PAY,    8'h01, 1'b0, 1'b0);
      5'd13:   w = uc(SRC_PAY,    8'h00, 1'b0, 1'b1);
      // time signature
      5'd14:   w = uc(SRC_VLQ,    8'h00, 1'b1, 1'b0);
      5'd15:   w = uc(SRC_CONST,  8'hFF, 1'b0, 1'b0);
      5'd16:   w = uc(SRC_CONST,  8'h58, 1'b0, 1'b0);
      5'd17:   w = uc(SRC_CONST,  8'h04, 1'b0, 1'b0);
      5'd18:   w = uc(SRC_PAY,    8'h03, 1'b0, 1'b0);
      5'd19:   w = uc(SRC_PAY,    8'h02, 1'b0, 1'b0);
      5'd20:   w = uc(SRC_PAY,    8'h01, 1'b0, 1'b0);
      5'd21:   w = uc(SRC_PAY,    8'h00, 1'b0, 1'b1);
      // end of track
      5'd22:   w = uc(SRC_CONST,  8'h00, 1'b0, 1'b0);
      5'd23:   w = uc(SRC_CONST,  8'hFF, 1'b0, 1'b0);
      5'd24:   w = uc(SRC_CONST,  8'h2F, 1'b0, 1'b0);
      5'd25:   w = uc(SRC_CONST,  8'h00, 1'b0, 1'b1);
      default: w = uc(SRC_CONST,  8'h00, 1'b0, 1'b1);
    endcase
    return w;
  endfunction

  function automatic upc_t entry_of(input logic [2:0] action);
    upc_t a;
    case (action)
      ACT_NOTE_OFF, ACT_NOTE_ON, ACT_POLY_AT: a = UA_NOTE;
      ACT_PROGRAM:   a = UA_PROG;
      ACT_TEMPO:     a = UA_TEMPO;
      ACT_TIME_SIG:  a = UA_TSIG;
      ACT_END_TRACK: a = UA_EOT;
      default:       a = UA_NOTE;
    endcase
    return a;
  endfunction

  // Index of the most significant nonzero 7-bit group (zero encodes as one group)
  function automatic logic [1:0] vlq_top(input logic [27:0] delta);
    logic [1:0] idx;
    priority if (delta[27:21] != 7'd0) idx = 2'd3;
    else if (delta[20:14] != 7'd0)     idx = 2'd2;
    else if (delta[13:7] != 7'd0)      idx = 2'd1;
    else                               idx = 2'd0;
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mte_if.sv =====
// Valid/ready channel interfaces for event input and byte output.
`default_nettype none

interface mte_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [27:0] delta_ticks;
  logic [3:0]  channel;
  logic [7:0]  param_one;
  logic [7:0]  param_two;
  logic [31:0] payload;

  modport source (output valid, action, delta_ticks, channel, param_one, param_two,
                  payload, input ready);
  modport sink (input valid, action, delta_ticks, channel, param_one, param_two,
                payload, output ready);
endinterface

interface mte_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mte_byte_sel.sv =====
// Byte datapath: forms the output byte named by the current control word.
`default_nettype none

module mte_byte_sel (
  input  mte_pkg::ucode_t  uw,
  input  mte_pkg::event_t  ev,
  input  logic [1:0]       vlq_idx,
  output logic [7:0]       data
);
  import mte_pkg::*;

  logic [6:0] group;
  logic [7:0] pay_byte;

  always_comb begin
    group    = ev.delta[7*vlq_idx +: 7];
    pay_byte = ev.payload[8*uw.lit[1:0] +: 8];
  end

  always_comb begin
    unique case (uw.src)
      SRC_CONST:  data = uw.lit;
      SRC_VLQ:    data = {vlq_idx != 2'd0, group};
      SRC_STATUS: data = uw.lit | {2'b00, ev.action[1:0], ev.channel};
      SRC_CHAN:   data = uw.lit | {4'h0, ev.channel};
      SRC_P1:     data = ev.p1;
      SRC_P2:     data = ev.p2;
      SRC_PAY:    data = pay_byte;
      default:    data = 8'h00;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/midi_track_event_encoder.sv =====
// Top level: microcoded encoder from MIDI track events to file byte sequences.
`default_nettype none

// Takes one track event per transfer and emits its Standard MIDI File bytes, one byte
// per output transfer, with last_byte set on the final one. A small microcode ROM
// holds one program per event kind (note off, note on and poly aftertouch share one);
// a step counter walks it and emits one byte per step, repeating the delta step once
// per 7-bit group. An event emits 3 to 11 bytes. A new event is taken as soon as the
// last byte of the previous one has been loaded into the output register. Action code
// 7 is taken and emits nothing.
module midi_track_event_encoder (
  input  logic               clk,
  input  logic               rst,
  mte_evt_if.sink            evt_in,
  mte_byte_if.source         byte_out
);
  import mte_pkg::*;

  logic        busy;
  upc_t        pc;
  logic [1:0]  vlq_idx;
  event_t      ev;
  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_last;

  ucode_t      uw;
  logic [7:0]  step_byte;
  logic        accept;
  logic        step;

  assign uw     = ucode_rom(pc);
  assign accept = evt_in.valid && evt_in.ready;
  assign step   = busy && (!out_valid || byte_out.ready);

  assign evt_in.ready       = !busy;
  assign byte_out.valid     = out_valid;
  assign byte_out.out_byte  = out_data;
  assign byte_out.last_byte = out_last;

  mte_byte_sel u_byte_sel (
    .uw      (uw),
    .ev      (ev),
    .vlq_idx (vlq_idx),
    .data    (step_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= UA_NOTE;
      vlq_idx   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pc      <= entry_of(evt_in.action);
        vlq_idx <= vlq_top(evt_in.delta_ticks);
        busy    <= (evt_in.action != ACT_NONE);
      end
      if (step) begin
        out_valid <= 1'b1;
        // stay on the delta step until the lowest group is out
        if (uw.loop && vlq_idx != 2'd0) begin
          vlq_idx <= vlq_idx - 2'd1;
        end else begin
          pc <= upc_t'(pc + 1'b1);
        end
        if (uw.last) begin
          busy <= 1'b0;
        end
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev.action  <= evt_in.action;
      ev.delta   <= evt_in.delta_ticks;
      ev.channel <= evt_in.channel;
      ev.p1      <= evt_in.param_one;
      ev.p2      <= evt_in.param_two;
      ev.payload <= evt_in.payload;
    end
    if (step) begin
      out_data <= step_byte;
      out_last <= uw.last;
    end
  end

`ifndef SYNTHESIS
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> out_valid && out_last)
    else $error("event finished without a last byte");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= UA_LAST)
    else $error("step counter left the program");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !step |=> busy && $stable(pc) && $stable(vlq_idx))
    else $error("sequencer advanced during an output stall");
`endif

endmodule

`default_nettype wire
